/* design/jfs_pkg.sv */
// ----------------------------------------------------------------------------
// jfs_pkg
// shared types, codes and helpers for the joint fault supervisor
// ----------------------------------------------------------------------------
package jfs_pkg;

    // event codes carried in a request
    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_HEARTBEAT = 3'd1,
        CMD_VELOCITY  = 3'd2,
        CMD_EVALUATE  = 3'd3,
        CMD_ACK       = 3'd4
    } cmd_e_t;

    // link watchdog status
    typedef enum logic [1:0] {
        LINK_STARTING = 2'd0,
        LINK_ONLINE   = 2'd1,
        LINK_OFFLINE  = 2'd2
    } link_status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_HB_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_GRACE        = 2'd1;
    localparam logic [1:0] CFG_CMD_TIMEOUT  = 2'd2;
    localparam logic [1:0] CFG_CRIT_MASK    = 2'd3;

    localparam logic [15:0] HB_TIMEOUT_RST  = 16'd2500;
    localparam logic [15:0] GRACE_RST       = 16'd5000;
    localparam logic [15:0] CMD_TIMEOUT_RST = 16'd1000;
    localparam logic [7:0]  CRIT_MASK_RST   = 8'd28;

    // driver error codes
    localparam logic [2:0] DRV_NONE        = 3'd0;
    localparam logic [2:0] DRV_COMM        = 3'd1;
    localparam logic [2:0] DRV_RB_DISABLED = 3'd2;
    localparam logic [2:0] DRV_RB_ENABLED  = 3'd3;
    localparam logic [2:0] DRV_CONFIG      = 3'd4;
    localparam logic [2:0] DRV_CRITICAL    = 3'd5;

    // snapshot flag bit positions
    localparam int FLG_UNDERVOLT  = 0;
    localparam int FLG_OTWARN     = 1;
    localparam int FLG_OVERTEMP   = 2;
    localparam int FLG_SHORT_GND  = 3;
    localparam int FLG_SHORT_SUP  = 4;
    localparam int FLG_DRV_ERROR  = 5;

    // fault bit positions
    localparam int F_COMM       = 0;
    localparam int F_READBACK   = 1;
    localparam int F_CONFIG     = 2;
    localparam int F_UNDERVOLT  = 3;
    localparam int F_OTWARN     = 4;
    localparam int F_OVERTEMP   = 5;
    localparam int F_SHORT      = 6;
    localparam int F_CRITICAL   = 7;
    localparam int F_CMDTIMEOUT = 8;
    localparam int F_LOGUNAVAIL = 9;
    localparam int F_LOGWRITE   = 10;

    localparam int FAULT_BITS = 11;
    localparam int DRV_BITS   = 8;

    localparam logic [FAULT_BITS-1:0] LEVEL_MASK = 11'h0EF;

    // stop causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_NET_OFF  = 3'd1;
    localparam logic [2:0] CAUSE_CTRL_OFF = 3'd2;
    localparam logic [2:0] CAUSE_CMD_TO   = 3'd3;
    localparam logic [2:0] CAUSE_DRIVER   = 3'd4;

    // severity levels
    localparam logic [1:0] LVL_NOMINAL  = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_DEGRADED = 2'd2;
    localparam logic [1:0] LVL_FAULT    = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ms;
        logic        sent_by_ctrl;
        logic        velocity_active;
        logic [2:0]  driver_error;
        logic [7:0]  snapshot_flags;
        logic        log_available;
        logic        log_write_ok;
    } jfs_req_t;

    typedef struct packed {
        logic                  halt_pulse;
        logic [FAULT_BITS-1:0] active_fault_bits;
        logic [FAULT_BITS-1:0] latched_fault_bits;
        logic [1:0]            fault_level;
        logic [1:0]            network_status;
        logic [1:0]            controller_status;
        logic [2:0]            stop_cause;
        logic                  log_request;
        logic [1:0]            log_fault_bits;
        logic                  remote_motion_ok;
    } jfs_rsp_t;

    // severity from the fault words and link states
    function automatic logic [1:0] fault_level_of(
        input logic [FAULT_BITS-1:0] active,
        input logic [FAULT_BITS-1:0] latched,
        input link_status_t          net,
        input link_status_t          ctrl
    );
        logic [1:0] lvl;
        if ((active & LEVEL_MASK) != '0)
            lvl = LVL_FAULT;
        else if (net == LINK_OFFLINE || ctrl == LINK_OFFLINE ||
                 active[F_LOGUNAVAIL] || active[F_LOGWRITE])
            lvl = LVL_DEGRADED;
        else if (latched[F_CMDTIMEOUT] || active[F_OTWARN])
            lvl = LVL_WARNING;
        else
            lvl = LVL_NOMINAL;
        return lvl;
    endfunction

endpackage

/* design/joint_fault_supervisor.sv */
// ----------------------------------------------------------------------------
// joint_fault_supervisor
// heartbeat and command watchdogs, driver fault decode and severity for one joint
// ----------------------------------------------------------------------------
// pipeline: an accepted request is held in the input register, then its result
//   in the result register; all event work sits between the two
// throughput: one request per cycle while the result side is not held; state is
//   updated as a request leaves the input register, so the next request sees it
// reset: rst_n async active low clears all state, links go to starting,
//   timeout and mask registers return to their defaults
module joint_fault_supervisor #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              item_valid,
    output logic              item_ready,
    input  jfs_pkg::jfs_req_t item,
    // result channel
    output logic              result_valid,
    input  logic              result_ready,
    output jfs_pkg::jfs_rsp_t result,
    // configuration writes
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import jfs_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] hb_timeout_reg;
    logic [15:0] grace_reg;
    logic [15:0] cmd_timeout_reg;
    logic [7:0]  crit_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_timeout_reg  <= HB_TIMEOUT_RST;
            grace_reg       <= GRACE_RST;
            cmd_timeout_reg <= CMD_TIMEOUT_RST;
            crit_mask_reg   <= CRIT_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HB_TIMEOUT:  hb_timeout_reg  <= cfg_data;
                CFG_GRACE:       grace_reg       <= cfg_data;
                CFG_CMD_TIMEOUT: cmd_timeout_reg <= cfg_data;
                CFG_CRIT_MASK:   crit_mask_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic     req_valid_reg;
    jfs_req_t req_reg;
    logic     result_valid_reg;
    jfs_rsp_t result_reg;
    jfs_rsp_t result_next;
    logic     result_free;
    logic     step;

    // result register can take a new value when empty or being drained
    assign result_free = !result_valid_reg || result_ready;
    // the held request is processed when the result side has room
    assign step        = req_valid_reg && result_free;
    // input register frees when its request moves on this cycle
    assign item_ready  = !req_valid_reg || result_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (item_ready)
            req_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            req_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_free)
            result_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // supervisor state
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0]  start_time_reg,     start_time_next;
    logic [TIME_BITS-1:0]  hb_time_reg,        hb_time_next;
    logic                  hb_heard_reg,       hb_heard_next;
    logic [TIME_BITS-1:0]  ctrl_time_reg,      ctrl_time_next;
    logic                  ctrl_heard_reg,     ctrl_heard_next;
    link_status_t          net_status_reg,     net_status_next;
    link_status_t          ctrl_status_reg,    ctrl_status_next;
    logic                  vel_live_reg,       vel_live_next;
    logic [TIME_BITS-1:0]  vel_time_reg,       vel_time_next;
    logic [FAULT_BITS-1:0] active_reg,         active_next;
    logic [FAULT_BITS-1:0] latched_reg,        latched_next;
    logic [1:0]            prev_pers_reg,      prev_pers_next;
    logic                  log_wr_failed_reg,  log_wr_failed_next;
    logic [2:0]            cause_reg,          cause_next;
    logic [1:0]            level_reg,          level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg    <= '0;
            hb_time_reg       <= '0;
            hb_heard_reg      <= 1'b0;
            ctrl_time_reg     <= '0;
            ctrl_heard_reg    <= 1'b0;
            net_status_reg    <= LINK_STARTING;
            ctrl_status_reg   <= LINK_STARTING;
            vel_live_reg      <= 1'b0;
            vel_time_reg      <= '0;
            active_reg        <= '0;
            latched_reg       <= '0;
            prev_pers_reg     <= '0;
            log_wr_failed_reg <= 1'b0;
            cause_reg         <= CAUSE_NONE;
            level_reg         <= LVL_NOMINAL;
        end
        else if (step)
        begin
            start_time_reg    <= start_time_next;
            hb_time_reg       <= hb_time_next;
            hb_heard_reg      <= hb_heard_next;
            ctrl_time_reg     <= ctrl_time_next;
            ctrl_heard_reg    <= ctrl_heard_next;
            net_status_reg    <= net_status_next;
            ctrl_status_reg   <= ctrl_status_next;
            vel_live_reg      <= vel_live_next;
            vel_time_reg      <= vel_time_next;
            active_reg        <= active_next;
            latched_reg       <= latched_next;
            prev_pers_reg     <= prev_pers_next;
            log_wr_failed_reg <= log_wr_failed_next;
            cause_reg         <= cause_next;
            level_reg         <= level_next;
        end
    end

    // ------------------------------------------------------------------
    // watchdog compares and driver decode
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] now_t;
    logic                 net_hb_expired;
    logic                 grace_expired;
    logic                 ctrl_hb_expired;
    logic                 vel_expired;
    logic [DRV_BITS-1:0]  drv_faults;

    // timestamps live in TIME_BITS, the port is 32 bits
    assign now_t = TIME_BITS'(req_reg.now_ms);

    jfs_age_check #(.TIME_BITS(TIME_BITS)) u_net_age (
        .now     (now_t),
        .stamp   (hb_time_reg),
        .limit   (hb_timeout_reg),
        .expired (net_hb_expired)
    );

    jfs_age_check #(.TIME_BITS(TIME_BITS)) u_grace_age (
        .now     (now_t),
        .stamp   (start_time_reg),
        .limit   (grace_reg),
        .expired (grace_expired)
    );

    jfs_age_check #(.TIME_BITS(TIME_BITS)) u_ctrl_age (
        .now     (now_t),
        .stamp   (ctrl_time_reg),
        .limit   (hb_timeout_reg),
        .expired (ctrl_hb_expired)
    );

    jfs_age_check #(.TIME_BITS(TIME_BITS)) u_vel_age (
        .now     (now_t),
        .stamp   (vel_time_reg),
        .limit   (cmd_timeout_reg),
        .expired (vel_expired)
    );

    jfs_drv_decode u_drv_decode (
        .driver_error   (req_reg.driver_error),
        .snapshot_flags (req_reg.snapshot_flags),
        .crit_mask      (crit_mask_reg),
        .drv_faults     (drv_faults)
    );

    // ------------------------------------------------------------------
    // event handling
    // ------------------------------------------------------------------
    logic       stop;
    logic       log_req;
    logic [1:0] log_bits;
    logic [1:0] pers;
    logic [1:0] fresh;
    logic       faults_clear;

    // driver-level faults were clear before this request
    assign faults_clear = (active_reg & LEVEL_MASK) == '0;

    always_comb
    begin
        start_time_next    = start_time_reg;
        hb_time_next       = hb_time_reg;
        hb_heard_next      = hb_heard_reg;
        ctrl_time_next     = ctrl_time_reg;
        ctrl_heard_next    = ctrl_heard_reg;
        net_status_next    = net_status_reg;
        ctrl_status_next   = ctrl_status_reg;
        vel_live_next      = vel_live_reg;
        vel_time_next      = vel_time_reg;
        active_next        = active_reg;
        latched_next       = latched_reg;
        prev_pers_next     = prev_pers_reg;
        log_wr_failed_next = log_wr_failed_reg;
        cause_next         = cause_reg;
        level_next         = level_reg;
        stop               = 1'b0;
        log_req            = 1'b0;
        log_bits           = '0;
        pers               = '0;
        fresh              = '0;

        unique case (req_reg.command)
            CMD_START:
            begin
                start_time_next  = now_t;
                net_status_next  = LINK_STARTING;
                ctrl_status_next = LINK_STARTING;
                if (!req_reg.log_available)
                begin
                    active_next[F_LOGUNAVAIL]  = 1'b1;
                    latched_next[F_LOGUNAVAIL] = 1'b1;
                end
                level_next = fault_level_of(active_next, latched_next,
                                            net_status_next, ctrl_status_next);
            end

            CMD_HEARTBEAT:
            begin
                // heartbeat does not refresh the level
                hb_heard_next   = 1'b1;
                hb_time_next    = now_t;
                net_status_next = LINK_ONLINE;
                if (req_reg.sent_by_ctrl)
                begin
                    ctrl_heard_next  = 1'b1;
                    ctrl_time_next   = now_t;
                    ctrl_status_next = LINK_ONLINE;
                end
            end

            CMD_VELOCITY:
            begin
                vel_live_next = req_reg.velocity_active;
                vel_time_next = now_t;
            end

            CMD_EVALUATE:
            begin
                // network watchdog: heartbeat age, or startup grace if never heard
                if (hb_heard_reg ? net_hb_expired : grace_expired)
                    net_status_next = LINK_OFFLINE;
                if (net_status_reg != LINK_OFFLINE && net_status_next == LINK_OFFLINE)
                begin
                    stop = 1'b1;
                    if (faults_clear)
                        cause_next = CAUSE_NET_OFF;
                end

                // controller watchdog only once the controller has spoken
                if (ctrl_heard_reg)
                begin
                    if (ctrl_hb_expired)
                        ctrl_status_next = LINK_OFFLINE;
                    if (ctrl_status_reg == LINK_ONLINE && ctrl_status_next == LINK_OFFLINE)
                    begin
                        stop = 1'b1;
                        if (faults_clear)
                            cause_next = CAUSE_CTRL_OFF;
                    end
                end

                // velocity command watchdog, latched only
                if (vel_live_reg && vel_expired)
                begin
                    stop                       = 1'b1;
                    latched_next[F_CMDTIMEOUT] = 1'b1;
                    cause_next                 = CAUSE_CMD_TO;
                end

                // refresh driver faults, keep the upper bits
                active_next[DRV_BITS-1:0] = drv_faults;
                if (((active_next & LEVEL_MASK) != '0) && faults_clear)
                    cause_next = CAUSE_DRIVER;

                // log bits are sticky until reset
                if (!req_reg.log_available)
                    active_next[F_LOGUNAVAIL] = 1'b1;
                if (log_wr_failed_reg)
                    active_next[F_LOGWRITE] = 1'b1;
                latched_next = latched_next | active_next;

                // rising edge of overtemp / short asks for a log record
                pers           = {active_next[F_SHORT], active_next[F_OVERTEMP]};
                fresh          = pers & ~prev_pers_reg;
                prev_pers_next = pers;
                if (fresh != '0)
                begin
                    log_req  = 1'b1;
                    log_bits = fresh;
                    if (!req_reg.log_write_ok)
                    begin
                        log_wr_failed_next       = 1'b1;
                        active_next[F_LOGWRITE]  = 1'b1;
                        latched_next[F_LOGWRITE] = 1'b1;
                    end
                end

                level_next = fault_level_of(active_next, latched_next,
                                            net_status_next, ctrl_status_next);
                // any stop event also kills the live velocity command
                if (stop)
                    vel_live_next = 1'b0;
            end

            CMD_ACK:
            begin
                // drop latched faults that are no longer active
                latched_next = latched_reg & active_reg;
                level_next   = fault_level_of(active_reg, latched_next,
                                              net_status_reg, ctrl_status_reg);
            end

            default:
                ;
        endcase
    end

    always_comb
    begin
        result_next.halt_pulse         = stop;
        result_next.active_fault_bits  = active_next;
        result_next.latched_fault_bits = latched_next;
        result_next.fault_level        = level_next;
        result_next.network_status     = net_status_next;
        result_next.controller_status  = ctrl_status_next;
        result_next.stop_cause         = cause_next;
        result_next.log_request        = log_req;
        result_next.log_fault_bits     = log_bits;
        result_next.remote_motion_ok   = ctrl_status_next == LINK_ONLINE;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // stall only when both stages are full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (req_valid_reg && result_valid_reg && !result_ready))
        else $error("request side stalled without a full pipeline");

    // only an evaluate can produce a stop or a log request
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && req_reg.command != CMD_EVALUATE) |=>
            (!result_reg.halt_pulse && !result_reg.log_request))
        else $error("stop or log request outside evaluate");

    // after an evaluate every active fault is also latched
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && req_reg.command == CMD_EVALUATE) |=>
            ((result_reg.active_fault_bits & ~result_reg.latched_fault_bits) == '0))
        else $error("active fault missing from latched word");

    // a log request always names at least one new fault
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.log_request) |-> (result.log_fault_bits != 2'd0))
        else $error("log request without fault bits");

endmodule

/* design/jfs_age_check.sv */
// ----------------------------------------------------------------------------
// jfs_age_check
// wrapping age of a timestamp compared against a millisecond limit
// ----------------------------------------------------------------------------
module jfs_age_check #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] now,
    input  logic [TIME_BITS-1:0] stamp,
    input  logic [15:0]          limit,
    output logic                 expired
);
    logic [TIME_BITS-1:0] age;

    // modulo 2^TIME_BITS difference
    assign age     = now - stamp;
    assign expired = age >= TIME_BITS'(limit);
endmodule

/* design/jfs_drv_decode.sv */
// ----------------------------------------------------------------------------
// jfs_drv_decode
// driver error code and snapshot flags to driver fault bits
// ----------------------------------------------------------------------------
module jfs_drv_decode (
    input  logic [2:0]                 driver_error,
    input  logic [7:0]                 snapshot_flags,
    input  logic [7:0]                 crit_mask,
    output logic [jfs_pkg::DRV_BITS-1:0] drv_faults
);
    import jfs_pkg::*;

    always_comb
    begin
        drv_faults = '0;
        case (driver_error) inside
            DRV_COMM:
                drv_faults[F_COMM] = 1'b1;
            DRV_RB_DISABLED, DRV_RB_ENABLED:
                drv_faults[F_READBACK] = 1'b1;
            DRV_CONFIG:
                drv_faults[F_CONFIG] = 1'b1;
            DRV_CRITICAL:
                // some flags already explain the critical code
                if ((snapshot_flags & crit_mask) == '0)
                    drv_faults[F_CRITICAL] = 1'b1;
            default:
                ;
        endcase
        if (snapshot_flags[FLG_UNDERVOLT])
            drv_faults[F_UNDERVOLT] = 1'b1;
        if (snapshot_flags[FLG_OTWARN])
            drv_faults[F_OTWARN] = 1'b1;
        if (snapshot_flags[FLG_OVERTEMP])
            drv_faults[F_OVERTEMP] = 1'b1;
        if (snapshot_flags[FLG_SHORT_GND] || snapshot_flags[FLG_SHORT_SUP])
            drv_faults[F_SHORT] = 1'b1;
        if (snapshot_flags[FLG_DRV_ERROR] && !snapshot_flags[FLG_OVERTEMP] &&
            !snapshot_flags[FLG_SHORT_GND] && !snapshot_flags[FLG_SHORT_SUP])
            drv_faults[F_CRITICAL] = 1'b1;
    end
endmodule
